@@ rtl/swfq_pkg.sv @@
// Package for the sliding window fold queue: operator and operation codes,
// controller states, the result request bundle and the fold operator.
// No dependencies.
package swfq_pkg;

  // fold operator codes; the unused code acts as signed max
  localparam logic [1:0] MODE_MAX = 2'd0;
  localparam logic [1:0] MODE_MIN = 2'd1;
  localparam logic [1:0] MODE_SUM = 2'd2;

  // operation codes of an input beat
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOPRD,
    ST_XFER,
    ST_RESULT
  } state_t;

  // snapshot handed to the result stage
  typedef struct packed {
    logic               fire;
    logic               front_nz;
    logic               back_nz;
    logic [COUNT_W-1:0] held;
    logic               rejected;
  } res_req_t;

  // a is the older operand, b the newer one
  function automatic logic [DATA_W-1:0] fold_combine(input logic [1:0]        mode,
                                                     input logic [DATA_W-1:0] a,
                                                     input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    case (mode)
      MODE_MIN: r = ($signed(b) < $signed(a)) ? b : a;
      MODE_SUM: r = a + b;
      default:  r = ($signed(a) < $signed(b)) ? b : a;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/swfq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/swfq_result.sv @@
// Result stage: combines the front top fold with the back fold and registers
// the result beat. Depends on swfq_pkg.
module swfq_result
  import swfq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  res_req_t            req,
  input  logic [1:0]          mode,
  input  logic [DATA_W-1:0]   top_fold,
  input  logic [DATA_W-1:0]   back_fold,
  output logic                out_valid,
  output logic [DATA_W-1:0]   out_window_fold,
  output logic                out_window_empty,
  output logic [COUNT_W-1:0]  out_held_count,
  output logic                out_push_rejected
);

  logic              valid_r;
  logic [DATA_W-1:0] fold_r;
  logic              empty_r;
  logic [COUNT_W-1:0] held_r;
  logic              rej_r;
  logic [DATA_W-1:0] fold_nxt;

  // fold of the whole window, oldest first
  always_comb begin
    if (req.front_nz) begin
      fold_nxt = req.back_nz ? fold_combine(mode, top_fold, back_fold) : top_fold;
    end else begin
      fold_nxt = req.back_nz ? back_fold : '0;
    end
  end

  // strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req.fire;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req.fire) begin
      fold_r  <= fold_nxt;
      empty_r <= !req.front_nz && !req.back_nz;
      held_r  <= req.held;
      rej_r   <= req.rejected;
    end
  end

  assign out_valid         = valid_r;
  assign out_window_fold   = fold_r;
  assign out_window_empty  = empty_r;
  assign out_held_count    = held_r;
  assign out_push_rejected = rej_r;

endmodule

@@ rtl/sliding_window_fold_queue.sv @@
// Top level of the sliding window fold queue: controller, front and back
// stack memories and the result stage. Depends on swfq_pkg, swfq_ram, swfq_result.
//
// A FIFO window of up to DEPTH signed 32-bit values that reports, for every
// accepted start beat, the fold of all held values oldest first under the
// configured operator (signed max, signed min or wrapping sum), plus count and
// flags. A push, a pop that leaves the front stack empty or finds the window
// empty, and a rejected push pass from start through ST_RESULT to the result
// strobe; a pop that uncovers a new front top first passes through ST_TOPRD to
// read the front fold memory. A pop that finds the front stack empty moves the
// back stack across, one value per cycle through the back value memory read
// port, in ST_XFER. busy is high from the cycle after acceptance until the
// cycle the result strobe shows, so a new start can be taken in that same
// cycle. Results come out for exactly one cycle and cannot be stalled. The
// memories need no clearing after reset. combine_mode may be written only
// while no item is in flight.
module sliding_window_fold_queue
  import swfq_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  // input beat
  input  logic                start,
  output logic                busy,
  input  logic                in_operation,
  input  logic [DATA_W-1:0]   in_value,
  // result beat
  output logic                out_valid,
  output logic [DATA_W-1:0]   out_window_fold,
  output logic                out_window_empty,
  output logic [COUNT_W-1:0]  out_held_count,
  output logic                out_push_rejected,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_combine_mode
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = (CW + 1 > COUNT_W) ? CW + 1 : COUNT_W;

  state_t            state_r, state_nxt;
  logic [1:0]        mode_r;
  logic [CW-1:0]     fc_r, fc_nxt;
  logic [CW-1:0]     bc_r, bc_nxt;
  logic [DATA_W-1:0] bf_r, bf_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [AW-1:0]     rp_r, rp_nxt;
  logic              rej_r, rej_nxt;

  logic [TW-1:0]     total;
  logic [CW-1:0]     bc_m1;
  logic [CW-1:0]     bc_m2;
  logic [CW-1:0]     fc_m2;
  logic [DATA_W-1:0] acc;

  logic              bv_we;
  logic [AW-1:0]     bv_waddr;
  logic [AW-1:0]     bv_raddr;
  logic [DATA_W-1:0] bv_rdata;
  logic              ff_we;
  logic [AW-1:0]     ff_raddr;
  logic [DATA_W-1:0] ff_rdata;

  logic              req_fire;
  res_req_t          req;

  assign total = TW'(fc_r) + TW'(bc_r);
  assign bc_m1 = bc_r - CW'(1);
  assign bc_m2 = bc_r - CW'(2);
  assign fc_m2 = fc_r - CW'(2);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // suffix fold built during a transfer; the value read is the older operand
  assign acc = (k_r == '0) ? bv_rdata : fold_combine(mode_r, bv_rdata, top_r);

  // back stack values
  swfq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_back_ram (
    .clk     (clk),
    .wr_en   (bv_we),
    .wr_addr (bv_waddr),
    .wr_data (in_value),
    .rd_addr (bv_raddr),
    .rd_data (bv_rdata)
  );

  // front stack suffix folds
  swfq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_front_ram (
    .clk     (clk),
    .wr_en   (ff_we),
    .wr_addr (k_r),
    .wr_data (acc),
    .rd_addr (ff_raddr),
    .rd_data (ff_rdata)
  );

  // state register and control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fc_r    <= '0;
      bc_r    <= '0;
      bf_r    <= '0;
      rej_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fc_r    <= fc_nxt;
      bc_r    <= bc_nxt;
      bf_r    <= bf_nxt;
      rej_r   <= rej_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    k_r   <= k_nxt;
    rp_r  <= rp_nxt;
  end

  // operator register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MAX;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_combine_mode;
    end
  end

  // next state and memory control
  always_comb begin
    state_nxt = state_r;
    fc_nxt    = fc_r;
    bc_nxt    = bc_r;
    bf_nxt    = bf_r;
    top_nxt   = top_r;
    k_nxt     = k_r;
    rp_nxt    = rp_r;
    rej_nxt   = rej_r;
    bv_we     = 1'b0;
    bv_waddr  = bc_r[AW-1:0];
    bv_raddr  = rp_r;
    ff_we     = 1'b0;
    ff_raddr  = fc_m2[AW-1:0];
    req_fire  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          rej_nxt   = 1'b0;
          state_nxt = ST_RESULT;
          if (in_operation == OP_PUSH) begin
            if (total >= TW'(DEPTH)) begin
              rej_nxt = 1'b1;
            end else begin
              bv_we  = 1'b1;
              bf_nxt = (bc_r == '0) ? in_value : fold_combine(mode_r, bf_r, in_value);
              bc_nxt = bc_r + CW'(1);
            end
          end else if (fc_r != '0) begin
            // drop the front top; fetch the fold below it
            fc_nxt = fc_r - CW'(1);
            if (fc_r >= CW'(2)) begin
              state_nxt = ST_TOPRD;
            end
          end else if (bc_r < CW'(2)) begin
            bc_nxt = '0;
            bf_nxt = '0;
          end else begin
            // start moving the back stack across, newest first
            bv_raddr  = bc_m1[AW-1:0];
            rp_nxt    = bc_m1[AW-1:0];
            k_nxt     = '0;
            state_nxt = ST_XFER;
          end
        end
      end
      ST_TOPRD: begin
        top_nxt   = ff_rdata;
        state_nxt = ST_RESULT;
      end
      ST_XFER: begin
        ff_we   = 1'b1;
        top_nxt = acc;
        if (CW'(k_r) == bc_m2) begin
          // oldest value is dropped, not stored
          fc_nxt    = bc_m1;
          bc_nxt    = '0;
          bf_nxt    = '0;
          state_nxt = ST_RESULT;
        end else begin
          k_nxt    = k_r + AW'(1);
          rp_nxt   = rp_r - AW'(1);
          bv_raddr = rp_r - AW'(1);
        end
      end
      ST_RESULT: begin
        req_fire  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // snapshot for the result stage
  assign req.fire     = req_fire;
  assign req.front_nz = (fc_r != '0);
  assign req.back_nz  = (bc_r != '0);
  assign req.held     = total[COUNT_W-1:0];
  assign req.rejected = rej_r;

  swfq_result u_result (
    .clk               (clk),
    .rst_n             (rst_n),
    .req               (req),
    .mode              (mode_r),
    .top_fold          (top_r),
    .back_fold         (bf_r),
    .out_valid         (out_valid),
    .out_window_fold   (out_window_fold),
    .out_window_empty  (out_window_empty),
    .out_held_count    (out_held_count),
    .out_push_rejected (out_push_rejected)
  );

endmodule

@@ rtl/swfq_checker.sv @@
// Port-level checker for the sliding window fold queue, bound to the top level.
// Depends on swfq_pkg and sliding_window_fold_queue.
module swfq_checker
  import swfq_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [DATA_W-1:0]  out_window_fold,
  input logic               out_window_empty,
  input logic [COUNT_W-1:0] out_held_count,
  input logic               out_push_rejected
);

  // an accepted beat keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // every result follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work in flight");

  // an empty window reads zero with a zero count
  a_empty_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_window_empty) |-> (out_window_fold == '0 && out_held_count == '0))
    else $error("empty window with nonzero fold or count");

  // a rejected push implies a full, hence nonempty, window
  a_reject_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_push_rejected) |-> !out_window_empty)
    else $error("push rejected on an empty window");

endmodule

bind sliding_window_fold_queue swfq_checker u_swfq_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_fold_queue: directed and random
// push/pop traffic under every fold operator, checked against a local model.
// Depends on swfq_pkg and the sliding_window_fold_queue RTL.
module testbench;
  import swfq_pkg::*;

  localparam int WINDOW_DEPTH = 256;
  localparam int STALL_LIMIT  = 4000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0]  fold;
    logic               empty;
    logic [COUNT_W-1:0] held;
    logic               rejected;
  } window_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_operation = OP_PUSH;
  logic [DATA_W-1:0]   in_value = '0;
  logic                out_valid;
  logic [DATA_W-1:0]   out_window_fold;
  logic                out_window_empty;
  logic [COUNT_W-1:0]  out_held_count;
  logic                out_push_rejected;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_combine_mode = MODE_MAX;

  // window model: two stacks plus the operator in force
  logic [1:0]          active_mode = MODE_MAX;
  logic [DATA_W-1:0]   suffix_folds [WINDOW_DEPTH];
  logic [DATA_W-1:0]   pushed_values [WINDOW_DEPTH];
  logic [DATA_W-1:0]   pushed_fold = '0;
  int                  suffix_count = 0;
  int                  pushed_count = 0;

  window_result_t      expected_results [$];
  int                  error_count = 0;
  int                  items_sent = 0;
  int                  results_checked = 0;
  int                  rejects_seen = 0;
  int                  stack_moves = 0;
  int                  mode_writes = 0;
  int                  stall_cycles = 0;
  bit                  gaps_on = 1'b1;

  sliding_window_fold_queue #(.DEPTH(WINDOW_DEPTH)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_window_fold   (out_window_fold),
    .out_window_empty  (out_window_empty),
    .out_held_count    (out_held_count),
    .out_push_rejected (out_push_rejected),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_combine_mode  (cfg_combine_mode)
  );

  always #10 clk = ~clk;

  // older operand first; the unused code falls back to signed max
  function automatic logic [DATA_W-1:0] fold_pair(input logic [DATA_W-1:0] older,
                                                  input logic [DATA_W-1:0] newer);
    logic signed [DATA_W-1:0] o;
    logic signed [DATA_W-1:0] n;
    o = older;
    n = newer;
    if (active_mode == MODE_SUM)
      return older + newer;
    if (active_mode == MODE_MIN)
      return (n < o) ? newer : older;
    return (o < n) ? newer : older;
  endfunction

  function automatic int window_size();
    return suffix_count + pushed_count;
  endfunction

  // advance the model by one beat and return what the block should report
  function automatic window_result_t apply_beat(input logic op, input logic [DATA_W-1:0] val);
    window_result_t r;
    logic [DATA_W-1:0] top;
    int n;
    r = '0;
    if (op == OP_PUSH) begin
      if (window_size() >= WINDOW_DEPTH) begin
        r.rejected = 1'b1;
      end else begin
        pushed_values[pushed_count] = val;
        pushed_fold = (pushed_count == 0) ? val : fold_pair(pushed_fold, val);
        pushed_count++;
      end
    end else if (window_size() != 0) begin
      if (suffix_count != 0) begin
        suffix_count--;
      end else begin
        // move the back stack across, newest value at the bottom
        n = pushed_count;
        stack_moves++;
        if (n >= 2) begin
          suffix_folds[0] = pushed_values[n-1];
          for (int k = 1; k + 1 < n; k++)
            suffix_folds[k] = fold_pair(pushed_values[n-1-k], suffix_folds[k-1]);
          suffix_count = n - 1;
        end
        pushed_count = 0;
        pushed_fold = '0;
      end
    end
    r.fold = '0;
    if (suffix_count == 0) begin
      if (pushed_count != 0)
        r.fold = pushed_fold;
    end else begin
      top = suffix_folds[suffix_count-1];
      r.fold = (pushed_count == 0) ? top : fold_pair(top, pushed_fold);
    end
    r.empty = (window_size() == 0);
    r.held  = COUNT_W'(window_size());
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // result checker: the receiver always takes the strobe
  always @(posedge clk) begin : check_results
    window_result_t want;
    if (rst_n && out_valid) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", out_window_fold, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_window_fold !== want.fold)
          report_mismatch("window_fold", out_window_fold, want.fold);
        if (out_window_empty !== want.empty)
          report_mismatch("window_empty", DATA_W'(out_window_empty), DATA_W'(want.empty));
        if (out_held_count !== want.held)
          report_mismatch("held_count", DATA_W'(out_held_count), DATA_W'(want.held));
        if (out_push_rejected !== want.rejected)
          report_mismatch("push_rejected", DATA_W'(out_push_rejected),
                          DATA_W'(want.rejected));
      end
    end
  end

  // watchdog on cycles with no beat moving anywhere
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("testbench: errors");
      $finish;
    end
  end

  // one input beat; start stays high into the next beat when no gap is taken
  task automatic send_item(input logic op, input logic [DATA_W-1:0] val);
    window_result_t want;
    if (gaps_on && $urandom_range(0, 99) < 23) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    do @(posedge clk); while (busy !== 1'b0);
    want = apply_beat(op, val);
    if (want.rejected)
      rejects_seen++;
    expected_results.insert(expected_results.size(), want);
    items_sent++;
  endtask

  task automatic push_value(input logic [DATA_W-1:0] val);
    send_item(OP_PUSH, val);
  endtask

  task automatic pop_oldest();
    send_item(OP_POP, $urandom);
  endtask

  // every beat returns a result, so an empty queue means the block is idle
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    wait_idle();
    cfg_valid        <= 1'b1;
    cfg_combine_mode <= mode;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    active_mode = mode;
    mode_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // extremes show up often so max/min/sum corner cases get hit
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4:       return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_traffic(input int count, input int push_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < push_pct)
        push_value(pick_value());
      else
        pop_oldest();
    end
  endtask

  // empty pops, extremes, transfers of several sizes, every operator
  task automatic test_directed();
    pop_oldest();
    push_value(32'h7fff_ffff);
    push_value(32'h8000_0000);
    push_value(32'h0000_0000);
    push_value(32'hffff_ffff);
    pop_oldest();
    pop_oldest();
    push_value(32'h0000_0005);
    pop_oldest();
    pop_oldest();
    pop_oldest();
    pop_oldest();
    write_mode(MODE_MIN);
    push_value(32'h8000_0000);
    push_value(32'h7fff_ffff);
    pop_oldest();
    write_mode(MODE_SUM);
    push_value(32'h7fff_ffff);
    push_value(32'h0000_0001);
    pop_oldest();
    write_mode(MODE_UNUSED);
    push_value(32'hffff_fff0);
    push_value(32'h0000_0003);
    pop_oldest();
    write_mode(MODE_MAX);
    pop_oldest();
  endtask

  task automatic test_random_traffic();
    logic [1:0] modes [4];
    modes = '{MODE_MAX, MODE_MIN, MODE_SUM, MODE_UNUSED};
    foreach (modes[m]) begin
      write_mode(modes[m]);
      random_traffic(40, 70);
      random_traffic(40, 50);
      random_traffic(25, 30);
      random_traffic(25, 85);
    end
  endtask

  // fill to capacity back to back, push past the top, then empty it again
  task automatic test_full_window();
    write_mode(logic'(0) ? MODE_MAX : 2'($urandom_range(0, 3)));
    while (window_size() != 0) pop_oldest();
    gaps_on = 1'b0;
    while (window_size() < WINDOW_DEPTH) push_value(pick_value());
    repeat (3) push_value(pick_value());
    gaps_on = 1'b1;
    pop_oldest();
    push_value(pick_value());
    push_value(pick_value());
    random_traffic(40, 60);
    while (window_size() != 0) pop_oldest();
    pop_oldest();
    pop_oldest();
  endtask

  // operator changes while stored folds still carry the old operator
  task automatic test_operator_switch();
    for (int i = 0; i < 6; i++) begin
      write_mode(2'($urandom_range(0, 3)));
      random_traffic(15, 65);
    end
    write_mode(MODE_MAX);
    write_mode(MODE_UNUSED);
    random_traffic(10, 50);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic();
    test_full_window();
    test_operator_switch();
    wait_idle();
    $display("run covered %0d beats, %0d results, %0d rejected pushes, %0d stack moves",
             items_sent, results_checked, rejects_seen, stack_moves);
    $display("operator register written %0d times, %0d mismatches", mode_writes, error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
